>>> rtl/ipv6bs_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the hash row table for the prefix-length search
// no dependencies
package ipv6bs_pkg;

	localparam int NUM_LENGTHS   = 128;
	localparam int DEF_TABLE_DEPTH = 1024;
	localparam logic [31:0] GOLDEN = 32'h9e3779b9;
	localparam int HASH_ROWS     = 18;

	typedef struct packed {
		logic [63:0] key_hi;
		logic [63:0] key_lo;
		logic [15:0] value;
		logic [1:0]  kind;
		logic [9:0]  link;
	} entry_t;

	// one row of the mix: which word is updated, shift amount and direction
	typedef struct packed {
		logic [1:0] role;
		logic [4:0] sh;
		logic       left;
	} row_info_t;

	function automatic row_info_t row_info(input logic [4:0] row);
		row_info_t r;
		logic [4:0] k;
		k = (row >= 5'd9) ? row - 5'd9 : row;
		case (k)
			5'd0: r = '{2'd0, 5'd13, 1'b0};
			5'd1: r = '{2'd1, 5'd8,  1'b1};
			5'd2: r = '{2'd2, 5'd13, 1'b0};
			5'd3: r = '{2'd0, 5'd12, 1'b0};
			5'd4: r = '{2'd1, 5'd16, 1'b1};
			5'd5: r = '{2'd2, 5'd5,  1'b0};
			5'd6: r = '{2'd0, 5'd3,  1'b0};
			5'd7: r = '{2'd1, 5'd10, 1'b1};
			5'd8: r = '{2'd2, 5'd15, 1'b0};
			default: r = '{2'd0, 5'd0, 1'b0};
		endcase
		return r;
	endfunction

endpackage

>>> rtl/ipv6_prefix_length_binary_search.sv
`timescale 1ns / 1ps
// ipv6 longest-prefix lookup by binary search over prefix lengths 0..127
// a lookup makes 7 or 8 probes (setup, hash start, the shared hash unit for 18 mix
// rows and 4 remainder steps, read, wait, compare) plus a read, wait and compare per chain link
// one item at a time: input stalls until the result is valid, and while the tables clear
// after reset a clearing pass empties the tables
module ipv6_prefix_length_binary_search #(
	parameter int TABLE_DEPTH = ipv6bs_pkg::DEF_TABLE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [63:0] addr_high,
	input  logic [63:0] addr_low,
	input  logic [6:0]  prefix_length,
	input  logic [9:0]  slot,
	input  logic [15:0] hop_value,
	input  logic [1:0]  entry_kind,
	input  logic [9:0]  link_slot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] next_hop,
	output logic        matched
);
	import ipv6bs_pkg::*;

	localparam int STORE_DEPTH = NUM_LENGTHS * TABLE_DEPTH;
	localparam int AW = $clog2(STORE_DEPTH);
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int SW = $clog2(TABLE_DEPTH + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_WRITE = 4'd1;
	localparam logic [3:0] S_SETUP = 4'd2;
	localparam logic [3:0] S_HSTRT = 4'd3;
	localparam logic [3:0] S_HASH  = 4'd4;
	localparam logic [3:0] S_RD    = 4'd5;
	localparam logic [3:0] S_WAIT  = 4'd6;
	localparam logic [3:0] S_CHK   = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	logic [3:0]  state_q;
	logic [63:0] hi_q, lo_q, mhi_q, mlo_q;
	logic [7:0]  low_q, hi1_q;
	logic [6:0]  mid_q;
	logic [15:0] best_q;
	logic        any_q;
	logic [IDX_W-1:0] idx_q;
	logic [SW-1:0] step_q;
	logic        first_q;
	entry_t      wr_q;
	logic [AW-1:0] wr_addr_q;
	logic        wr_ok_q;
	logic        out_valid_q;
	logic [15:0] next_hop_q;
	logic        matched_q;

	logic        h_done;
	logic [IDX_W-1:0] h_idx;
	logic        t_we, t_ready;
	logic [AW-1:0] t_addr;
	entry_t      t_rdata;
	logic [7:0]  mid_w;
	logic        key_eq;
	logic        link_end;

	ipv6bs_hash #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_hash (
		.clk(clk), .arst_n(arst_n), .start(state_q == S_HSTRT),
		.key_hi(mhi_q), .key_lo(mlo_q), .done(h_done), .idx(h_idx)
	);

	ipv6bs_table #(.TABLE_DEPTH(TABLE_DEPTH), .STORE_DEPTH(STORE_DEPTH), .AW(AW)) u_table (
		.clk(clk), .arst_n(arst_n), .we(t_we), .addr(t_addr),
		.wdata(wr_q), .rdata(t_rdata), .ready(t_ready)
	);

	assign in_stall = (state_q != S_IDLE) || !t_ready;
	// a slot past the table depth is dropped
	assign t_we     = (state_q == S_WRITE) && wr_ok_q;
	assign t_addr   = (state_q == S_WRITE) ? wr_addr_q
		: AW'(mid_q) * AW'(TABLE_DEPTH) + AW'(idx_q);
	assign mid_w    = (low_q + hi1_q - 8'd1) >> 1;
	assign key_eq   = (t_rdata.key_hi == mhi_q) && (t_rdata.key_lo == mlo_q);
	assign link_end = (t_rdata.link == 10'd0) || (32'(t_rdata.link) >= TABLE_DEPTH)
		|| (step_q + 1'b1 == SW'(TABLE_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && t_ready)
						state_q <= action ? S_WRITE : S_SETUP;
				end
				S_WRITE: state_q <= S_OUT;
				S_SETUP: state_q <= (low_q < hi1_q) ? S_HSTRT : S_OUT;
				S_HSTRT: state_q <= S_HASH;
				S_HASH:  if (h_done) state_q <= S_RD;
				S_RD:    state_q <= S_WAIT;
				S_WAIT:  state_q <= S_CHK;
				S_CHK: begin
					if ((first_q && t_rdata.kind == 2'd0) || key_eq || link_end)
						state_q <= S_SETUP;
					else
						state_q <= S_RD;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				hi_q   <= addr_high;
				lo_q   <= addr_low;
				low_q  <= 8'd0;
				hi1_q  <= 8'd128;
				best_q <= '0;
				any_q  <= 1'b0;
				wr_q   <= '{addr_high, addr_low, hop_value, entry_kind, link_slot};
				wr_addr_q <= AW'(prefix_length) * AW'(TABLE_DEPTH) + AW'(slot);
				wr_ok_q <= (32'(slot) < TABLE_DEPTH);
			end
			S_WRITE: begin
				best_q <= '0;
				any_q  <= 1'b0;
			end
			S_SETUP: begin
				mid_q <= mid_w[6:0];
				if (mid_w == 8'd0) begin
					mhi_q <= '0;
					mlo_q <= '0;
				end else if (mid_w <= 8'd64) begin
					mhi_q <= hi_q & (~64'd0 << (8'd64 - mid_w));
					mlo_q <= '0;
				end else begin
					mhi_q <= hi_q;
					mlo_q <= lo_q & (~64'd0 << (8'd128 - mid_w));
				end
			end
			S_HASH: begin
				idx_q   <= h_idx;
				step_q  <= '0;
				first_q <= 1'b1;
			end
			S_CHK: begin
				first_q <= 1'b0;
				step_q  <= step_q + 1'b1;
				idx_q   <= IDX_W'(t_rdata.link);
				if (first_q && t_rdata.kind == 2'd0) begin
					hi1_q <= {1'b0, mid_q};
				end else if (key_eq) begin
					// an empty entry with value zero counts as a miss
					if (t_rdata.value == 16'd0 && t_rdata.kind == 2'd0) begin
						hi1_q <= {1'b0, mid_q};
					end else begin
						best_q <= t_rdata.value;
						any_q  <= 1'b1;
						low_q  <= {1'b0, mid_q} + 8'd1;
					end
				end else if (link_end) begin
					hi1_q <= {1'b0, mid_q};
				end
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					next_hop_q <= best_q;
					matched_q  <= any_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign next_hop  = next_hop_q;
	assign matched   = matched_q;

endmodule

>>> rtl/ipv6bs_hash.sv
`timescale 1ns / 1ps
// two-round mix hash of a 128-bit key, one mix row per cycle, then the remainder modulo the
// table depth by reciprocal multiplication (low half, high half, quotient times depth, remainder); uses ipv6bs_pkg
module ipv6bs_hash #(
	parameter int TABLE_DEPTH = ipv6bs_pkg::DEF_TABLE_DEPTH,
	parameter int IDX_W = $clog2(TABLE_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [63:0]       key_hi,
	input  logic [63:0]       key_lo,
	output logic              done,
	output logic [IDX_W-1:0]  idx
);
	import ipv6bs_pkg::*;

	localparam logic [1:0] P_IDLE = 2'd0;
	localparam logic [1:0] P_MIX  = 2'd1;
	localparam logic [1:0] P_MOD  = 2'd2;
	localparam int SHIFT = 32 + IDX_W;
	// ceil(2^SHIFT / depth) gives the exact quotient of any 32-bit word
	localparam logic [32:0] RECIP = 33'(((64'd1 << SHIFT) + 64'(TABLE_DEPTH) - 64'd1)
		/ 64'(TABLE_DEPTH));
	localparam logic [31:0] DEPTH = 32'(TABLE_DEPTH);
	localparam logic [4:0] MOD_LAST = 5'd3;

	logic [1:0]  phase_q;
	logic [4:0]  row_q;
	logic [31:0] a_q, b_q, c_q, k3_q;
	logic [64:0] prod_q;
	logic [31:0] qd_q;
	logic [IDX_W-1:0] rem_q;
	logic        done_q;

	row_info_t   ri;
	logic [31:0] x, y, z, zs, res;
	logic [15:0] mul_in;
	logic [48:0] part;
	logic [31:0] quot, diff;

	always_comb begin
		ri = row_info(row_q);
		case (ri.role)
			2'd0: begin x = a_q; y = b_q; z = c_q; end
			2'd1: begin x = b_q; y = c_q; z = a_q; end
			default: begin x = c_q; y = a_q; z = b_q; end
		endcase
		zs = ri.left ? (z << ri.sh) : (z >> ri.sh);
		res = (x - y - z) ^ zs;
		// hash times reciprocal, one 16-bit half per cycle
		mul_in = row_q[0] ? c_q[31:16] : c_q[15:0];
		part   = mul_in * RECIP;
		quot   = 32'(prod_q >> SHIFT);
		diff   = c_q - qd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_IDLE;
			row_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				P_IDLE: begin
					if (start) begin
						phase_q <= P_MIX;
						row_q   <= '0;
					end
				end
				P_MIX: begin
					if (row_q == 5'(HASH_ROWS - 1)) begin
						phase_q <= P_MOD;
						row_q   <= '0;
					end else begin
						row_q <= row_q + 5'd1;
					end
				end
				P_MOD: begin
					if (row_q == MOD_LAST) begin
						phase_q <= P_IDLE;
						done_q  <= 1'b1;
					end
					row_q <= row_q + 5'd1;
				end
				default: phase_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == P_IDLE && start) begin
			a_q   <= GOLDEN + key_lo[63:32];
			b_q   <= GOLDEN + key_lo[31:0];
			c_q   <= key_hi[63:32];
			k3_q  <= key_hi[31:0];
		end else if (phase_q == P_MIX) begin
			case (ri.role)
				2'd0: a_q <= res;
				2'd1: b_q <= res;
				default: begin
					c_q <= (row_q == 5'd8) ? res + 32'd16 : res;
					// end of first round: fold in the last key word
					if (row_q == 5'd8)
						a_q <= a_q + k3_q;
				end
			endcase
		end else if (phase_q == P_MOD) begin
			case (row_q)
				5'd0: prod_q <= {16'd0, part};
				5'd1: prod_q <= prod_q + {part, 16'd0};
				5'd2: qd_q <= quot * DEPTH;
				default: rem_q <= diff[IDX_W-1:0];
			endcase
		end
	end

	assign done = done_q;
	assign idx  = rem_q;

endmodule

>>> rtl/ipv6bs_table.sv
`timescale 1ns / 1ps
// entry memory for all per-length tables, with a clearing pass after reset
// uses ipv6bs_pkg
module ipv6bs_table #(
	parameter int TABLE_DEPTH = ipv6bs_pkg::DEF_TABLE_DEPTH,
	parameter int STORE_DEPTH = ipv6bs_pkg::NUM_LENGTHS * TABLE_DEPTH,
	parameter int AW = $clog2(STORE_DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                we,
	input  logic [AW-1:0]       addr,
	input  ipv6bs_pkg::entry_t  wdata,
	output ipv6bs_pkg::entry_t  rdata,
	output logic                ready
);
	import ipv6bs_pkg::*;

	entry_t        mem [STORE_DEPTH];
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == AW'(STORE_DEPTH - 1))
				clearing_q <= 1'b0;
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q)
			mem[clr_addr_q] <= '0;
		else if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end

	assign ready = !clearing_q;

endmodule
